// ===== rtl/second_order_iir_lowpass_macros.svh =====
// Assertion macros used by the checker file of the IIR low-pass block.
`ifndef SECOND_ORDER_IIR_LOWPASS_MACROS_SVH
`define SECOND_ORDER_IIR_LOWPASS_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SOIIR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SOIIR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/soiir_pkg.sv =====
// Shared constants and types for the second-order IIR low-pass filter.
package soiir_pkg;

   typedef logic [1:0] reg_index_type;
   typedef logic [1:0] fill_type;

   localparam reg_index_type REG_COEF_A = 2'd0;
   localparam reg_index_type REG_COEF_B = 2'd1;
   localparam reg_index_type REG_COEF_C = 2'd2;

   // samples that pass through unchanged before filtering starts
   localparam fill_type WARMUP_LEN = 2'd2;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

endpackage

// ===== rtl/soiir_datapath.sv =====
// Filter arithmetic and sample/output history for the IIR low-pass filter.
module soiir_datapath #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic signed [SAMPLE_WIDTH-1:0]      sample,
   input  logic signed [COEF_FRAC_BITS+3:0]    coef_a,
   input  logic signed [COEF_FRAC_BITS+3:0]    coef_b,
   input  logic signed [COEF_FRAC_BITS+3:0]    coef_c,
   output logic signed [SAMPLE_WIDTH-1:0]      filtered,
   output logic                                clipped
);

   localparam int CW = COEF_FRAC_BITS + 4;
   localparam int TW = SAMPLE_WIDTH + 2;
   localparam int AW = CW + SAMPLE_WIDTH + 3;
   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);

   logic signed [SAMPLE_WIDTH-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   soiir_pkg::fill_type            fill_ff, fill_in;

   logic signed [TW-1:0]              taps;
   logic signed [CW+TW-1:0]           prod_a;
   logic signed [CW+SAMPLE_WIDTH-1:0] prod_b, prod_c;
   logic signed [AW-1:0]              acc;
   logic [AW-COEF_FRAC_BITS-SAMPLE_WIDTH:0] acc_hi;
   logic                              fits;
   logic                              warm;

   assign warm = (fill_ff < soiir_pkg::WARMUP_LEN);

   always_comb begin
      taps   = {{2{sample[SAMPLE_WIDTH-1]}}, sample}
             + {x1_ff[SAMPLE_WIDTH-1], x1_ff, 1'b0}
             + {{2{x2_ff[SAMPLE_WIDTH-1]}}, x2_ff};
      prod_a = coef_a * taps;
      prod_b = coef_b * y1_ff;
      prod_c = coef_c * y2_ff;
      acc    = AW'(prod_a) - AW'(prod_b) - AW'(prod_c) + ROUND_HALF;
      // rounded value is acc[AW-1:FRAC]; it fits when the bits from the sample
      // sign upward all agree
      acc_hi = acc[AW-1:COEF_FRAC_BITS+SAMPLE_WIDTH-1];
      fits   = (&acc_hi) | ~(|acc_hi);
      if (warm) begin
         filtered = sample;
         clipped  = 1'b0;
      end else if (fits) begin
         filtered = acc[COEF_FRAC_BITS+SAMPLE_WIDTH-1:COEF_FRAC_BITS];
         clipped  = 1'b0;
      end else begin
         filtered = {acc[AW-1], {(SAMPLE_WIDTH-1){~acc[AW-1]}}};
         clipped  = 1'b1;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (step && warm) begin
         fill_in = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // history is only read once warm-up has overwritten it
   always_ff @(posedge clock) begin
      if (step) begin
         x1_ff <= sample;
         x2_ff <= x1_ff;
         y1_ff <= filtered;
         y2_ff <= y1_ff;
      end
   end

endmodule

// ===== rtl/second_order_iir_lowpass.sv =====
// Second-order low-pass IIR filter (direct form 1) on a sample stream, top level.
//
// Takes one sample per clock and returns one filtered sample per accepted sample,
// y = A*(x + 2*x1 + x2) - B*y1 - C*y2 with Q3.16-style coefficients, rounded to
// nearest (ties up) and saturated, rsp_tuser flagging saturation. The first two
// samples after reset pass through unchanged. An accepted sample goes into an input
// register, then through the full multiply-accumulate in one pass into the result
// register, which drives rsp_tvalid; the three coefficient multipliers and the
// accumulate/saturate adder set the clock period. Throughput is one sample every
// cycle while rsp_tready stays high. Coefficients are written over the APB port
// (coef_a at 0x0, coef_b at 0x4, coef_c at 0x8); the user must write them only
// while the stream is idle, which the block itself does not enforce.
module second_order_iir_lowpass #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,   // [SW-1:0] sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     rsp_tdata,   // [SW-1:0] filtered
   output logic [0:0]                            rsp_tuser,   // [0] clipped
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [soiir_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [soiir_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [soiir_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   localparam int CW = COEF_FRAC_BITS + 4;
   localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int XW = soiir_pkg::CSR_DATA_WIDTH - CW;

   logic signed [CW-1:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic signed [CW-1:0] coef_a_in, coef_b_in, coef_c_in;

   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           out_valid_ff, out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] y_ff;
   logic                           clip_ff;

   logic                           req_accept, advance, csr_write;
   logic signed [SAMPLE_WIDTH-1:0] dp_filtered;
   logic                           dp_clipped;
   soiir_pkg::reg_index_type       csr_index;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      coef_c_in = coef_c_ff;
      if (csr_write) begin
         unique case (csr_index)
            soiir_pkg::REG_COEF_A: coef_a_in = csr_pwdata[CW-1:0];
            soiir_pkg::REG_COEF_B: coef_b_in = csr_pwdata[CW-1:0];
            soiir_pkg::REG_COEF_C: coef_c_in = csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         soiir_pkg::REG_COEF_A: csr_prdata = {{XW{coef_a_ff[CW-1]}}, coef_a_ff};
         soiir_pkg::REG_COEF_B: csr_prdata = {{XW{coef_b_ff[CW-1]}}, coef_b_ff};
         soiir_pkg::REG_COEF_C: csr_prdata = {{XW{coef_c_ff[CW-1]}}, coef_c_ff};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
      end else begin
         coef_a_ff <= coef_a_in;
         coef_b_ff <= coef_b_in;
         coef_c_ff <= coef_c_in;
      end
   end

   // stream control: input register, single-pass compute, result register
   assign advance      = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | advance;
   assign req_accept   = req_tvalid & req_tready;
   assign in_valid_in  = req_accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
      if (advance) begin
         y_ff    <= dp_filtered;
         clip_ff <= dp_clipped;
      end
   end

   soiir_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .sample   (x_ff),
      .coef_a   (coef_a_ff),
      .coef_b   (coef_b_ff),
      .coef_c   (coef_c_ff),
      .filtered (dp_filtered),
      .clipped  (dp_clipped)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DW'(unsigned'(y_ff));
   assign rsp_tuser  = clip_ff;

endmodule

// ===== rtl/soiir_checker.sv =====
// Port-level assertions for the IIR low-pass filter, bound to the top level.
`include "second_order_iir_lowpass_macros.svh"

module soiir_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   localparam logic [SAMPLE_WIDTH-1:0] YMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] YMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   `SOIIR_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `SOIIR_ASSERT(a_clip_bound, rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[SAMPLE_WIDTH-1:0] == YMAX) || (rsp_tdata[SAMPLE_WIDTH-1:0] == YMIN), "clip flag without saturated value")
   `SOIIR_ASSERT(a_latency, req_tvalid && req_tready |-> ##2 rsp_tvalid, "accepted sample produced no result")
   `SOIIR_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind second_order_iir_lowpass soiir_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_soiir_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
